// ===== design/lbs_pkg.sv =====
// Shared types, constants and saturation helpers for the skinning block.
package lbs_pkg;

  // Default bone count of the matrix store.
  localparam int BONE_COUNT_DEFAULT = 64;

  // Request opcodes.
  localparam logic OP_MAT_WRITE = 1'b0;
  localparam logic OP_INFLUENCE = 1'b1;

  // Widths of the shared divide / square root unit.
  localparam int DIV_W  = 50;
  localparam int QUO_W  = DIV_W + 1;
  localparam int SQ_W   = 62;
  localparam int ROOT_W = 31;

  // One request: a matrix element write or one bone influence.
  typedef struct packed {
    logic               opcode;
    logic [5:0]         bone;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        weight;
    logic               last_influence;
  } req_t;

  // One blended vertex.
  typedef struct packed {
    logic signed [31:0] skinned_x;
    logic signed [31:0] skinned_y;
    logic signed [31:0] skinned_z;
    logic signed [15:0] skinned_nx;
    logic signed [15:0] skinned_ny;
    logic signed [15:0] skinned_nz;
    logic [15:0]        weight_sum;
    logic               degenerate;
  } rsp_t;

  // Command to the divide / square root unit.
  typedef struct packed {
    logic start;
    logic sqrt_op;
  } ds_ctl_t;

  // Cofactor operand elements: cof = a*b - c*d, row-major element numbers.
  localparam logic [3:0] COF_SEL [9][4] = '{
    '{4'd5, 4'd10, 4'd6, 4'd9},
    '{4'd6, 4'd8,  4'd4, 4'd10},
    '{4'd4, 4'd9,  4'd5, 4'd8},
    '{4'd2, 4'd9,  4'd1, 4'd10},
    '{4'd0, 4'd10, 4'd2, 4'd8},
    '{4'd1, 4'd8,  4'd0, 4'd9},
    '{4'd1, 4'd6,  4'd2, 4'd5},
    '{4'd2, 4'd4,  4'd0, 4'd6},
    '{4'd0, 4'd5,  4'd1, 4'd4}
  };

  // Clamp to 32-bit signed.
  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] res;
    if (v > 51'sd2147483647) res = 32'sh7FFFFFFF;
    else if (v < -51'sd2147483648) res = 32'sh80000000;
    else res = v[31:0];
    return res;
  endfunction

  // Clamp to 48-bit signed.
  function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
    logic signed [47:0] res;
    if (v > 51'sd140737488355327) res = 48'sh7FFFFFFFFFFF;
    else if (v < -51'sd140737488355328) res = 48'sh800000000000;
    else res = v[47:0];
    return res;
  endfunction

endpackage

// ===== design/linear_blend_vertex_skinning.sv =====
// Linear blend skinning top level: matrix store, shared multiplier, sequencer.
// A matrix element write is taken while the sequencer is idle. An influence keeps req_ready
// low until it is done (the normal part is skipped when the bone matrix is singular), and the
// last influence of a vertex keeps it low through normalization as well. The time is set
// by the one 33x33 multiplier, whose products each go through memory read, operand load,
// multiply and accumulate, and by the shared divide / square root unit, which makes
// one quotient or root bit per cycle for the three normal divides, the square root and
// the three normalizing divides. A finished vertex waits in an output register, so the
// next vertex proceeds while it is not yet taken.
module linear_blend_vertex_skinning #(
  parameter int BONE_COUNT = lbs_pkg::BONE_COUNT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lbs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lbs_pkg::rsp_t rsp
);

  localparam int MEM_DEPTH = BONE_COUNT * 16;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DW        = lbs_pkg::DIV_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_POS   = 4'd1;
  localparam logic [3:0] ST_POSW  = 4'd2;
  localparam logic [3:0] ST_COF   = 4'd3;
  localparam logic [3:0] ST_DET   = 4'd4;
  localparam logic [3:0] ST_NRM   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_NRMW  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;
  localparam logic [3:0] ST_NMAG  = 4'd9;
  localparam logic [3:0] ST_SHIFT = 4'd10;
  localparam logic [3:0] ST_SQ    = 4'd11;
  localparam logic [3:0] ST_SQRT  = 4'd12;
  localparam logic [3:0] ST_QDIV  = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  // Sequencer
  logic [3:0] state;
  logic [1:0] ph;
  logic [1:0] r;
  logic [1:0] k;
  logic [3:0] ci;
  logic       cj;

  // Captured request and datapath
  lbs_pkg::req_t       cur;
  logic                bone_ok;
  logic signed [32:0]  op_a, op_b;
  logic signed [32:0]  op_a_sel, op_b_sel;
  logic signed [65:0]  prod;
  logic signed [49:0]  tacc;
  logic signed [49:0]  det;
  logic signed [49:0]  det_next;
  logic signed [49:0]  fs16;
  logic signed [47:0]  acc_p [3];
  logic signed [47:0]  acc_n [3];
  logic [16:0]         wacc;
  logic [17:0]         wsum;
  logic                degen;
  logic                nzero;
  logic [47:0]         mag [3];
  logic [2:0]          nneg;
  logic [61:0]         sumsq;
  logic [30:0]         len;
  logic signed [15:0]  nout [3];
  logic signed [15:0]  qv;
  logic                mag_big, mag_small;

  // Memories
  logic [31:0]         mat_mem [MEM_DEPTH];
  logic [31:0]         rd_a, rd_b;
  logic signed [31:0]  cof_mem [9];
  logic signed [31:0]  cof_rd;
  logic                cof_we;
  logic signed [31:0]  cof_wdata;

  logic [3:0]          elem_a, elem_b, cof_addr;
  logic [ADDR_W-1:0]   addr_a, addr_b;
  logic signed [31:0]  m_a, m_b;
  logic signed [31:0]  p_k;
  logic signed [15:0]  n_k;
  logic [47:0]         mag_k;

  // Divide / square root unit
  lbs_pkg::ds_ctl_t                      ds_ctl;
  logic signed [DW-1:0]                  ds_num, ds_den;
  logic                                  ds_done;
  logic signed [lbs_pkg::QUO_W-1:0]      ds_quot;
  logic [lbs_pkg::ROOT_W-1:0]            ds_root;

  lbs_divsqrt u_ds (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ds_ctl),
    .num  (ds_num),
    .den  (ds_den),
    .rad  (sumsq),
    .done (ds_done),
    .quot (ds_quot),
    .root (ds_root)
  );

  assign req_ready = (state == ST_IDLE);

  // Per-index selects
  always_comb begin
    unique case (k)
      2'd0:    begin p_k = cur.pos_x; n_k = cur.norm_x; mag_k = mag[0]; end
      2'd1:    begin p_k = cur.pos_y; n_k = cur.norm_y; mag_k = mag[1]; end
      default: begin p_k = cur.pos_z; n_k = cur.norm_z; mag_k = mag[2]; end
    endcase
  end

  // Read addresses
  always_comb begin
    elem_a   = '0;
    elem_b   = '0;
    cof_addr = '0;
    unique case (state)
      ST_POS: elem_a = {r, k};
      ST_COF: begin
        elem_a = lbs_pkg::COF_SEL[ci][{cj, 1'b0}];
        elem_b = lbs_pkg::COF_SEL[ci][{cj, 1'b1}];
      end
      ST_DET: begin
        elem_a   = {2'b00, k};
        cof_addr = {2'b00, k};
      end
      ST_NRM: cof_addr = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, k};
      default: ;
    endcase
  end

  assign addr_a = ADDR_W'({cur.bone, elem_a});
  assign addr_b = ADDR_W'({cur.bone, elem_b});
  assign m_a    = bone_ok ? $signed(rd_a) : 32'sd0;
  assign m_b    = bone_ok ? $signed(rd_b) : 32'sd0;

  // Multiplier operand select
  always_comb begin
    op_a_sel = '0;
    op_b_sel = '0;
    unique case (state)
      ST_POS: begin
        op_a_sel = 33'(m_a);
        op_b_sel = (k == 2'd3) ? 33'sd65536 : 33'(p_k);
      end
      ST_POSW: begin
        op_a_sel = 33'(lbs_pkg::sat32(51'(tacc)));
        op_b_sel = $signed({17'd0, cur.weight});
      end
      ST_COF: begin
        op_a_sel = 33'(m_a);
        op_b_sel = 33'(m_b);
      end
      ST_DET: begin
        op_a_sel = 33'(m_a);
        op_b_sel = 33'(cof_rd);
      end
      ST_NRM: begin
        op_a_sel = 33'(cof_rd);
        op_b_sel = 33'(n_k);
      end
      ST_NRMW: begin
        op_a_sel = 33'(lbs_pkg::sat32(ds_quot));
        op_b_sel = $signed({17'd0, cur.weight});
      end
      ST_SQ: begin
        op_a_sel = $signed({1'b0, mag_k[31:0]});
        op_b_sel = $signed({1'b0, mag_k[31:0]});
      end
      default: ;
    endcase
  end

  // Unit command and operands
  always_comb begin
    ds_ctl.start   = (ph == 2'd0) &&
                     (state == ST_DIV || state == ST_SQRT || state == ST_QDIV);
    ds_ctl.sqrt_op = (state == ST_SQRT);
    ds_num = (state == ST_QDIV) ? $signed(DW'({mag_k[30:0], 14'd0})) : tacc;
    ds_den = (state == ST_QDIV) ? $signed(DW'(len)) : det;
  end

  // Misc datapath terms
  always_comb begin
    fs16      = $signed(prod[65:16]);
    det_next  = ((k == 2'd0) ? 50'sd0 : det) + fs16;
    cof_wdata = lbs_pkg::sat32(51'(tacc) - 51'(fs16));
    cof_we    = (state == ST_COF) && (ph == 2'd3) && cj;
    wsum      = {1'b0, wacc} + {2'b00, req.weight};
    qv        = ds_quot[15:0];
    mag_big   = |{mag[0][47:30], mag[1][47:30], mag[2][47:30]};
    mag_small = !(mag[0][29] | mag[1][29] | mag[2][29]);
  end

  // Matrix store, two registered read ports
  always_ff @(posedge clk) begin
    if (req_valid && req_ready && (req.opcode == lbs_pkg::OP_MAT_WRITE) &&
        (32'(req.bone) < 32'(BONE_COUNT))) begin
      mat_mem[ADDR_W'({req.bone, req.element_index})] <= req.element_value;
    end
    rd_a <= mat_mem[addr_a];
    rd_b <= mat_mem[addr_b];
  end

  // Cofactor store
  always_ff @(posedge clk) begin
    if (cof_we) cof_mem[ci] <= cof_wdata;
    cof_rd <= cof_mem[cof_addr];
  end

  // Shared multiplier
  always_ff @(posedge clk) begin
    if (ph == 2'd1) begin
      op_a <= op_a_sel;
      op_b <= op_b_sel;
    end
    prod <= op_a * op_b;
  end

  // Sequencer and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ph        <= '0;
      r         <= '0;
      k         <= '0;
      ci        <= '0;
      cj        <= 1'b0;
      rsp_valid <= 1'b0;
      wacc      <= '0;
      degen     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_p[i] <= '0;
        acc_n[i] <= '0;
      end
    end else begin
      // ST_OUT reloads the output register itself when it is taken
      if (rsp_valid && rsp_ready && (state != ST_OUT)) rsp_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_valid && (req.opcode == lbs_pkg::OP_INFLUENCE)) begin
            cur     <= req;
            bone_ok <= 32'(req.bone) < 32'(BONE_COUNT);
            wacc    <= wsum[17] ? 17'h1FFFF : wsum[16:0];
            r       <= '0;
            k       <= '0;
            ph      <= '0;
            state   <= ST_POS;
          end
        end
        ST_POS, ST_POSW, ST_COF, ST_DET, ST_NRM, ST_NRMW, ST_SQ: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            unique case (state)
              ST_POS: begin
                tacc <= ((k == 2'd0) ? 50'sd0 : tacc) + fs16;
                if (k == 2'd3) state <= ST_POSW;
                else k <= k + 2'd1;
              end
              ST_POSW: begin
                acc_p[r] <= lbs_pkg::sat48(51'(acc_p[r]) + $signed(prod[65:15]));
                k <= '0;
                if (r == 2'd2) begin
                  ci    <= '0;
                  cj    <= 1'b0;
                  state <= ST_COF;
                end else begin
                  r     <= r + 2'd1;
                  state <= ST_POS;
                end
              end
              ST_COF: begin
                if (!cj) begin
                  tacc <= fs16;
                  cj   <= 1'b1;
                end else begin
                  cj <= 1'b0;
                  if (ci == 4'd8) begin
                    k     <= '0;
                    state <= ST_DET;
                  end else begin
                    ci <= ci + 4'd1;
                  end
                end
              end
              ST_DET: begin
                det <= det_next;
                if (k == 2'd2) begin
                  k <= '0;
                  r <= '0;
                  if (det_next == 50'sd0) begin
                    degen <= 1'b1;
                    state <= ST_FIN;
                  end else begin
                    state <= ST_NRM;
                  end
                end else begin
                  k <= k + 2'd1;
                end
              end
              ST_NRM: begin
                tacc <= ((k == 2'd0) ? 50'sd0 : tacc) + $signed(prod[49:0]);
                if (k == 2'd2) state <= ST_DIV;
                else k <= k + 2'd1;
              end
              ST_NRMW: begin
                acc_n[r] <= lbs_pkg::sat48(51'(acc_n[r]) + $signed(prod[65:15]));
                k <= '0;
                if (r == 2'd2) begin
                  state <= ST_FIN;
                end else begin
                  r     <= r + 2'd1;
                  state <= ST_NRM;
                end
              end
              default: begin
                sumsq <= ((k == 2'd0) ? 62'd0 : sumsq) + prod[61:0];
                if (k == 2'd2) state <= ST_SQRT;
                else k <= k + 2'd1;
              end
            endcase
          end
        end
        ST_DIV, ST_SQRT, ST_QDIV: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else if (ds_done) begin
            ph <= '0;
            unique case (state)
              ST_DIV:  state <= ST_NRMW;
              ST_SQRT: begin
                len   <= ds_root;
                k     <= '0;
                state <= ST_QDIV;
              end
              default: begin
                nout[k] <= nneg[k] ? -qv : qv;
                if (k == 2'd2) state <= ST_OUT;
                else k <= k + 2'd1;
              end
            endcase
          end
        end
        ST_FIN: begin
          ph    <= '0;
          state <= cur.last_influence ? ST_NMAG : ST_IDLE;
        end
        ST_NMAG: begin
          for (int i = 0; i < 3; i++) begin
            mag[i]  <= acc_n[i][47] ? 48'(-acc_n[i]) : 48'(acc_n[i]);
            nneg[i] <= acc_n[i][47];
          end
          nzero <= (acc_n[0] == 48'sd0) && (acc_n[1] == 48'sd0) && (acc_n[2] == 48'sd0);
          if ((acc_n[0] == 48'sd0) && (acc_n[1] == 48'sd0) && (acc_n[2] == 48'sd0)) begin
            for (int i = 0; i < 3; i++) nout[i] <= '0;
            state <= ST_OUT;
          end else begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          priority if (mag_big) begin
            for (int i = 0; i < 3; i++) mag[i] <= {1'b0, mag[i][47:1]};
          end else if (mag_small) begin
            for (int i = 0; i < 3; i++) mag[i] <= {mag[i][46:0], 1'b0};
          end else begin
            k     <= '0;
            ph    <= '0;
            state <= ST_SQ;
          end
        end
        ST_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.skinned_x  <= lbs_pkg::sat32(51'(acc_p[0]));
            rsp.skinned_y  <= lbs_pkg::sat32(51'(acc_p[1]));
            rsp.skinned_z  <= lbs_pkg::sat32(51'(acc_p[2]));
            rsp.skinned_nx <= nout[0];
            rsp.skinned_ny <= nout[1];
            rsp.skinned_nz <= nout[2];
            rsp.weight_sum <= wacc[16] ? 16'hFFFF : wacc[15:0];
            rsp.degenerate <= degen | nzero;
            rsp_valid      <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              acc_p[i] <= '0;
              acc_n[i] <= '0;
            end
            wacc  <= '0;
            degen <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/lbs_divsqrt.sv =====
// Shared iterative unit: signed divide (truncating) or integer square root, one bit a cycle.
module lbs_divsqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lbs_pkg::ds_ctl_t                     ctl,
  input  logic signed [lbs_pkg::DIV_W-1:0]     num,
  input  logic signed [lbs_pkg::DIV_W-1:0]     den,
  input  logic [lbs_pkg::SQ_W-1:0]             rad,
  output logic                                 done,
  output logic signed [lbs_pkg::QUO_W-1:0]     quot,
  output logic [lbs_pkg::ROOT_W-1:0]           root
);

  localparam int DW = lbs_pkg::DIV_W;
  localparam int RW = lbs_pkg::ROOT_W;
  localparam int SW = lbs_pkg::SQ_W;
  localparam logic [5:0] DIV_LAST = 6'(DW - 1);
  localparam logic [5:0] SQ_LAST  = 6'(RW - 1);

  logic          busy;
  logic          is_sqrt;
  logic [5:0]    cnt;
  logic [DW-1:0] qsh;
  logic [DW:0]   rem;
  logic [DW-1:0] dmag;
  logic          neg;
  logic [SW-1:0] sh;
  logic [RW+3:0] srem;
  logic [RW-1:0] sroot;

  logic [DW:0]   rem_sh;
  logic [DW+1:0] rdiff;
  logic [RW+3:0] srem_sh;
  logic [RW+3:0] trial;
  logic [RW+4:0] sdiff;

  // Restoring divide and digit-by-digit root step
  always_comb begin
    rem_sh  = {rem[DW-1:0], qsh[DW-1]};
    rdiff   = {1'b0, rem_sh} - {2'b00, dmag};
    srem_sh = {srem[RW+1:0], sh[SW-1:SW-2]};
    trial   = {2'b00, sroot, 2'b01};
    sdiff   = {1'b0, srem_sh} - {1'b0, trial};
  end

  assign quot = neg ? -$signed({1'b0, qsh}) : $signed({1'b0, qsh});
  assign root = sroot;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy    <= 1'b1;
        is_sqrt <= ctl.sqrt_op;
        cnt     <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if ((is_sqrt && cnt == SQ_LAST) || (!is_sqrt && cnt == DIV_LAST)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      qsh   <= num[DW-1] ? DW'(-num) : DW'(num);
      dmag  <= den[DW-1] ? DW'(-den) : DW'(den);
      neg   <= num[DW-1] ^ den[DW-1];
      rem   <= '0;
      sh    <= rad;
      srem  <= '0;
      sroot <= '0;
    end else if (busy) begin
      if (is_sqrt) begin
        sh <= {sh[SW-3:0], 2'b00};
        if (!sdiff[RW+4]) begin
          srem  <= sdiff[RW+3:0];
          sroot <= {sroot[RW-2:0], 1'b1};
        end else begin
          srem  <= srem_sh;
          sroot <= {sroot[RW-2:0], 1'b0};
        end
      end else begin
        if (!rdiff[DW+1]) begin
          rem <= rdiff[DW:0];
          qsh <= {qsh[DW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          qsh <= {qsh[DW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ===== sim/tb_linear_blend_vertex_skinning.sv =====
// Self-checking testbench for the linear blend skinning block: bone matrix writes and influences.
module tb_linear_blend_vertex_skinning;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      NUM_BONES   = 64;
  localparam int      RANDOM_REQS = 1250;
  localparam int      IDLE_LIMIT  = 12000;
  localparam int      HOLD_CYCLES = 3000;
  localparam int      DRAIN_WAIT  = 1000;
  localparam longint  ACC_HI      = 64'sh00007FFFFFFFFFFF;
  localparam longint  ACC_LO      = -ACC_HI - 1;
  localparam longint  W32_HI      = 64'sh000000007FFFFFFF;
  localparam longint  W32_LO      = -W32_HI - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  lbs_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  lbs_pkg::rsp_t rsp;

  linear_blend_vertex_skinning #(.BONE_COUNT(NUM_BONES)) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Pending requests, expected vertices, error count
  lbs_pkg::req_t   pending_q[$];
  lbs_pkg::rsp_t   vertex_expect_q[$];
  int     errors = 0;
  int     accepted_reqs = 0;
  int     idle_cycles = 0;

  // Predictor state
  logic signed [31:0] pose_mat[NUM_BONES][16];
  longint             pos_acc[3];
  longint             nrm_acc[3];
  longint             wsum_acc;
  bit                 degen_seen;

  // Generator side: which matrix elements have been written so far
  bit                 gen_written[NUM_BONES][16];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint cofactor(longint a, longint b, longint c, longint d);
    return clamp(((a * b) >>> 16) - ((c * d) >>> 16), W32_LO, W32_HI);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Apply one accepted request to the predictor; queue a vertex on the last influence
  task automatic skin_predict(lbs_pkg::req_t r);
    longint m[16], p[3], n[3], c[9];
    longint det, w, t, s, u;
    longint unsigned mag[3], mx, sum, len, q;
    int shr, shl;
    lbs_pkg::rsp_t v;
    if (r.opcode == lbs_pkg::OP_MAT_WRITE) begin
      pose_mat[r.bone][r.element_index] = r.element_value;
      return;
    end
    for (int k = 0; k < 16; k++) m[k] = pose_mat[r.bone][k];
    p[0] = r.pos_x;  p[1] = r.pos_y;  p[2] = r.pos_z;
    n[0] = r.norm_x; n[1] = r.norm_y; n[2] = r.norm_z;
    w = longint'({48'd0, r.weight});
    // position rows
    for (int i = 0; i < 3; i++) begin
      t = m[i*4+3];
      for (int k = 0; k < 3; k++) t += (m[i*4+k] * p[k]) >>> 16;
      t = clamp(t, W32_LO, W32_HI);
      pos_acc[i] = clamp(pos_acc[i] + ((t * w) >>> 15), ACC_LO, ACC_HI);
    end
    // inverse-transpose via cofactors
    c[0] = cofactor(m[5], m[10], m[6], m[9]);
    c[1] = cofactor(m[6], m[8],  m[4], m[10]);
    c[2] = cofactor(m[4], m[9],  m[5], m[8]);
    c[3] = cofactor(m[2], m[9],  m[1], m[10]);
    c[4] = cofactor(m[0], m[10], m[2], m[8]);
    c[5] = cofactor(m[1], m[8],  m[0], m[9]);
    c[6] = cofactor(m[1], m[6],  m[2], m[5]);
    c[7] = cofactor(m[2], m[4],  m[0], m[6]);
    c[8] = cofactor(m[0], m[5],  m[1], m[4]);
    det = ((m[0] * c[0]) >>> 16) + ((m[1] * c[1]) >>> 16) + ((m[2] * c[2]) >>> 16);
    if (det == 0) begin
      degen_seen = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        s = c[i*3] * n[0] + c[i*3+1] * n[1] + c[i*3+2] * n[2];
        u = clamp(s / det, W32_LO, W32_HI);
        nrm_acc[i] = clamp(nrm_acc[i] + ((u * w) >>> 15), ACC_LO, ACC_HI);
      end
    end
    wsum_acc = wsum_acc + w;
    if (wsum_acc > 131071) wsum_acc = 131071;
    if (!r.last_influence) return;

    // normalize the blended normal
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = nrm_acc[k] < 0 ? -nrm_acc[k] : nrm_acc[k];
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) begin
      degen_seen = 1'b1;
      v.skinned_nx = '0; v.skinned_ny = '0; v.skinned_nz = '0;
    end else begin
      shr = 0; shl = 0; sum = 0;
      while (mx >= (64'd1 << 30)) begin mx = mx >> 1; shr++; end
      while (mx < (64'd1 << 29)) begin mx = mx << 1; shl++; end
      for (int k = 0; k < 3; k++) begin
        mag[k] = (mag[k] >> shr) << shl;
        sum += mag[k] * mag[k];
      end
      len = int_sqrt(sum);
      q = (mag[0] * 16384) / len;
      v.skinned_nx = 16'(nrm_acc[0] < 0 ? -q : q);
      q = (mag[1] * 16384) / len;
      v.skinned_ny = 16'(nrm_acc[1] < 0 ? -q : q);
      q = (mag[2] * 16384) / len;
      v.skinned_nz = 16'(nrm_acc[2] < 0 ? -q : q);
    end
    v.skinned_x  = 32'(clamp(pos_acc[0], W32_LO, W32_HI));
    v.skinned_y  = 32'(clamp(pos_acc[1], W32_LO, W32_HI));
    v.skinned_z  = 32'(clamp(pos_acc[2], W32_LO, W32_HI));
    v.weight_sum = wsum_acc > 65535 ? 16'hFFFF : wsum_acc[15:0];
    v.degenerate = degen_seen;
    vertex_expect_q.push_back(v);
    for (int k = 0; k < 3; k++) begin pos_acc[k] = 0; nrm_acc[k] = 0; end
    wsum_acc = 0;
    degen_seen = 1'b0;
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Fully random request; callers overwrite the fields they care about
  function automatic lbs_pkg::req_t noise_req();
    lbs_pkg::req_t r;
    r.opcode         = 1'($urandom_range(0, 1));
    r.bone           = 6'($urandom_range(0, 63));
    r.element_index  = 4'($urandom_range(0, 15));
    r.element_value  = $urandom;
    r.pos_x          = $urandom;
    r.pos_y          = $urandom;
    r.pos_z          = $urandom;
    r.norm_x         = 16'($urandom);
    r.norm_y         = 16'($urandom);
    r.norm_z         = 16'($urandom);
    r.weight         = 16'($urandom_range(0, 32768));
    r.last_influence = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic push_mat_write(int bone, int elem, logic [31:0] val);
    lbs_pkg::req_t r;
    r = noise_req();
    r.opcode        = lbs_pkg::OP_MAT_WRITE;
    r.bone          = 6'(bone);
    r.element_index = 4'(elem);
    r.element_value = val;
    gen_written[bone][elem] = 1'b1;
    pending_q.push_back(r);
  endtask

  task automatic push_influence(int bone, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                logic [15:0] wt, logic last);
    lbs_pkg::req_t r;
    r = noise_req();
    r.opcode = lbs_pkg::OP_INFLUENCE;
    r.bone = 6'(bone);
    r.pos_x = px; r.pos_y = py; r.pos_z = pz;
    r.norm_x = nx; r.norm_y = ny; r.norm_z = nz;
    r.weight = wt;
    r.last_influence = last;
    pending_q.push_back(r);
  endtask

  function automatic logic [31:0] rand_elem();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return $urandom;
    if (pick < 3) return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    if (pick < 4) return 32'd0;
    return $signed($urandom_range(0, 262143)) - 131072;
  endfunction

  function automatic logic [31:0] rand_pos();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 2097151)) - 1048576;
  endfunction

  function automatic bit bone_ready(int b);
    for (int k = 0; k < 16; k++) if (!gen_written[b][k]) return 1'b0;
    return 1'b1;
  endfunction

  // Stimulus: matrix setup, directed vertices, then random mix
  initial begin
    int bones_ok[$];
    int nvx, nb;
    bit zero_n;
    for (int b = 0; b < NUM_BONES; b++)
      for (int k = 0; k < 16; k++) gen_written[b][k] = 1'b0;
    for (int k = 0; k < 3; k++) begin pos_acc[k] = 0; nrm_acc[k] = 0; end
    wsum_acc = 0;
    degen_seen = 1'b0;

    // bone 0 identity, 1 singular, 2 all max, 3 all min, 4..7 random
    for (int k = 0; k < 16; k++) begin
      push_mat_write(0, k, (k % 5 == 0) ? 32'h00010000 : 32'd0);
      push_mat_write(1, k, 32'd0);
      push_mat_write(2, k, 32'h7FFFFFFF);
      push_mat_write(3, k, 32'h80000000);
      for (int b = 4; b < 8; b++) push_mat_write(b, k, rand_elem());
    end
    // directed influences
    push_influence(0, 32'h7FFFFFFF, 32'h80000000, 32'd0, 16'h7FFF, 16'h8000, 16'd0,
                   16'd32768, 1'b1);
    push_influence(0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 16'h4000, 16'h0, 16'h0,
                   16'd0, 1'b1);
    push_influence(1, 32'h00010000, 32'h00010000, 32'h00010000, 16'h4000, 16'h4000,
                   16'h0, 16'd16384, 1'b1);
    push_influence(0, 32'h00010000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'd32768, 1'b1);
    push_influence(2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF,
                   16'h7FFF, 16'd32768, 1'b0);
    push_influence(3, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
                   16'h8000, 16'd32768, 1'b1);
    // weight sum saturation across five full-weight influences
    for (int i = 0; i < 5; i++)
      push_influence(i == 1 ? 1 : 0, 32'h00020000, 32'hFFFF0000, 32'h00001234, 16'h2D41,
                     16'hD2BF, 16'h0100, 16'd32768, i == 4);
    push_influence(4, rand_pos(), rand_pos(), rand_pos(), 16'h1000, 16'h2000, 16'h3000,
                   16'd20000, 1'b0);
    push_influence(5, rand_pos(), rand_pos(), rand_pos(), 16'hF000, 16'h0800, 16'h3FFF,
                   16'd12768, 1'b1);

    // random part: whole vertices with random content, interleaved matrix updates
    while (pending_q.size() < RANDOM_REQS) begin
      if ($urandom_range(0, 5) == 0) begin
        nb = $urandom_range(0, 63);
        push_mat_write(nb, $urandom_range(0, 15), rand_elem());
        continue;
      end
      bones_ok.delete();
      for (int b = 0; b < NUM_BONES; b++) if (bone_ready(b)) bones_ok.push_back(b);
      nvx = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      zero_n = ($urandom_range(0, 15) == 0);
      for (int i = 0; i < nvx; i++) begin
        nb = bones_ok[$urandom_range(0, bones_ok.size() - 1)];
        push_influence(nb, rand_pos(), rand_pos(), rand_pos(),
                       zero_n ? 16'd0 : 16'($urandom),
                       zero_n ? 16'd0 : 16'($urandom),
                       zero_n ? 16'd0 : 16'($urandom),
                       ($urandom_range(0, 7) == 0) ? 16'd32768 : 16'($urandom_range(0, 32768)),
                       i == nvx - 1);
      end
    end

    // drain
    wait (pending_q.size() == 0 && !req_valid);
    wait (vertex_expect_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("tb_linear_blend_vertex_skinning: clean");
    end else begin
      $display("tb_linear_blend_vertex_skinning: errors");
    end
    $finish;
  end

  // Reset
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int pick_gap(bit burst);
    int pick;
    if (burst) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Request driver
  int req_gap = 0;
  bit req_burst = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        skin_predict(req);
        accepted_reqs++;
      end
      if (!req_valid || req_ready) begin
        if ($urandom_range(0, 199) == 0) req_burst = ~req_burst;
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req <= pending_q.pop_front();
          req_valid <= 1'b1;
          req_gap = pick_gap(req_burst);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall, with one long hold to back up the block
  int rsp_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit rsp_burst = 1'b0;
  lbs_pkg::rsp_t vx;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (vertex_expect_q.size() == 0) begin
          $error("vertex result with none expected");
          errors++;
        end else begin
          vx = vertex_expect_q.pop_front();
          compare_field("skinned_x", vx.skinned_x, rsp.skinned_x);
          compare_field("skinned_y", vx.skinned_y, rsp.skinned_y);
          compare_field("skinned_z", vx.skinned_z, rsp.skinned_z);
          compare_field("skinned_nx", vx.skinned_nx, rsp.skinned_nx);
          compare_field("skinned_ny", vx.skinned_ny, rsp.skinned_ny);
          compare_field("skinned_nz", vx.skinned_nz, rsp.skinned_nz);
          compare_field("weight_sum", vx.weight_sum, rsp.weight_sum);
          compare_field("degenerate", vx.degenerate, rsp.degenerate);
        end
      end
      if (!hold_done && accepted_reqs >= 400) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) rsp_burst = ~rsp_burst;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        rsp_gap = pick_gap(rsp_burst);
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_linear_blend_vertex_skinning: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
design/lbs_pkg.sv
design/lbs_divsqrt.sv
design/linear_blend_vertex_skinning.sv
sim/tb_linear_blend_vertex_skinning.sv
